// ----- hw/rtl/mec_pkg.sv -----
// Shared constants, codes and widths for the motion event classifier.
package mec_pkg;

  localparam int WINDOW_SAMPLES = 200;
  localparam int SEEN_W = $clog2(WINDOW_SAMPLES + 1);

  localparam logic [15:0] ONE_G    = 16'd16384;
  localparam logic [15:0] FULL     = 16'd65535;
  localparam logic [15:0] TILT_MAX = 16'd23040;

  // Root unit: two radicand bits per step
  localparam int ROOT_STEPS = 16;
  localparam int ROOT_CW    = $clog2(ROOT_STEPS);
  // Divider: one quotient bit per step
  localparam int QUOT_STEPS = 16;
  localparam int QUOT_CW    = $clog2(QUOT_STEPS);

  localparam logic [1:0] CLS_IDLE      = 2'd0;
  localparam logic [1:0] CLS_TREMOR    = 2'd1;
  localparam logic [1:0] CLS_LANDSLIDE = 2'd2;
  localparam logic [1:0] CLS_SEISMIC   = 2'd3;

  localparam logic [1:0] SRC_WARMUP     = 2'd0;
  localparam logic [1:0] SRC_MODEL      = 2'd1;
  localparam logic [1:0] SRC_RULE       = 2'd2;
  localparam logic [1:0] SRC_RULE_OVER  = 2'd3;

  localparam logic [2:0] REG_TREMOR_ACCEL    = 3'd0;
  localparam logic [2:0] REG_TREMOR_GYRO     = 3'd1;
  localparam logic [2:0] REG_SEISMIC_ACCEL   = 3'd2;
  localparam logic [2:0] REG_SEISMIC_GYRO    = 3'd3;
  localparam logic [2:0] REG_LANDSLIDE_TILT  = 3'd4;
  localparam logic [2:0] REG_LANDSLIDE_ACCEL = 3'd5;
  localparam logic [2:0] REG_EVENT_HOLD      = 3'd6;

endpackage

// ----- hw/rtl/mec_sqrt.sv -----
// Iterative floor square root, 32-bit radicand, two bits per cycle.
module mec_sqrt import mec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);

  logic               busy;
  logic [ROOT_CW-1:0] cnt;
  logic [31:0]        rad;
  logic [16:0]        rem;
  logic [18:0]        rem_sh;
  logic [18:0]        trial;
  logic               fits;

  // one digit step
  assign rem_sh = {rem, rad[31:30]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == ROOT_CW'(ROOT_STEPS - 1));
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= {rad[29:0], 2'b00};
        rem  <= fits ? 17'(rem_sh - trial) : rem_sh[16:0];
        root <= {root[14:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == ROOT_CW'(ROOT_STEPS - 1)) busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/mec_div.sv -----
// Iterative restoring divider, 16-bit quotient, one bit per cycle.
module mec_div import mec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot
);

  logic               busy;
  logic [QUOT_CW-1:0] cnt;
  logic [15:0]        low;
  logic [15:0]        rem;
  logic [15:0]        dsr;
  logic [16:0]        rem_sh;
  logic               fits;

  // high half is below the divisor wherever the quotient is used
  assign rem_sh = {rem, low[15]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == QUOT_CW'(QUOT_STEPS - 1));
      if (start) begin
        rem  <= dividend[31:16];
        low  <= dividend[15:0];
        dsr  <= divisor;
        quot <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        low  <= {low[14:0], 1'b0};
        rem  <= fits ? 16'(rem_sh - {1'b0, dsr}) : rem_sh[15:0];
        quot <= {quot[14:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == QUOT_CW'(QUOT_STEPS - 1)) busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/motion_event_classifier.sv -----
// From the accepting edge to the result beat: squaring, two roots, averaging,
// four divisions, rule class, a confidence division and merge (each root or division
// a start, its steps and a hand-off). One sample at a time, on the shared root unit and divider.
// A finished result waits in the output register while the next sample is taken.
// No new sample until the last one merges; a waiting result stalls only the next merge.
// Synchronous reset restores register defaults and clears averages, hold and warm-up.
module motion_event_classifier import mec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [14:0] roll_angle,
  input  logic signed [14:0] pitch_angle,
  input  logic               model_valid,
  input  logic [1:0]         model_class,
  input  logic [15:0]        model_confidence,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         event_class,
  output logic [15:0]        event_confidence,
  output logic [1:0]         event_source,
  output logic [15:0]        motion_score,
  output logic [15:0]        linear_accel_smoothed,
  output logic [15:0]        gyro_mag_smoothed,
  output logic [14:0]        tilt_smoothed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQUARE = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_AVG    = 8'b0000_1000,
    S_DIVIDE = 8'b0001_0000,
    S_CLASS  = 8'b0010_0000,
    S_CONF   = 8'b0100_0000,
    S_MERGE  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] tremor_accel_level, tremor_gyro_level;
  logic [15:0] seismic_accel_level, seismic_gyro_level;
  logic [14:0] landslide_tilt_level;
  logic [15:0] landslide_accel_level, hold_time;

  // latched sample
  logic signed [15:0] axis [6];
  logic signed [14:0] roll, pitch;
  logic        mvalid;
  logic [1:0]  mclass;
  logic [15:0] mconf;
  logic [31:0] now;

  // block state
  logic [15:0] accel_avg, gyro_avg;
  logic [14:0] tilt_avg;
  logic [SEEN_W-1:0] samples_seen;
  logic [1:0]  held_class, held_source;
  logic [15:0] held_conf;
  logic [31:0] hold_deadline;

  // working registers
  logic [2:0]  sq_step;
  logic [31:0] prod, sum_g, sum_a;
  logic        root_idx;
  logic [15:0] gmag, amag;
  logic [14:0] tilt_sat;
  logic [1:0]  div_idx;
  logic [15:0] score;
  logic [1:0]  rclass;
  logic [15:0] rconf;
  logic        launched;

  logic        sqrt_start, sqrt_done, div_start, div_done;
  logic [15:0] sqrt_root, quot;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        merge_fire;

  assign cfg_ready  = 1'b1;
  assign in_stall   = state != S_IDLE;
  assign merge_fire = (state == S_MERGE) && (!out_valid || !out_stall);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tremor_accel_level    <= 16'd1311;
      tremor_gyro_level     <= 16'd2304;
      seismic_accel_level   <= 16'd4588;
      seismic_gyro_level    <= 16'd11520;
      landslide_tilt_level  <= 15'd1792;
      landslide_accel_level <= 16'd819;
      hold_time             <= 16'd1200;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TREMOR_ACCEL:    tremor_accel_level    <= cfg_data;
        REG_TREMOR_GYRO:     tremor_gyro_level     <= cfg_data;
        REG_SEISMIC_ACCEL:   seismic_accel_level   <= cfg_data;
        REG_SEISMIC_GYRO:    seismic_gyro_level    <= cfg_data;
        REG_LANDSLIDE_TILT:  landslide_tilt_level  <= cfg_data[14:0];
        REG_LANDSLIDE_ACCEL: landslide_accel_level <= cfg_data;
        REG_EVENT_HOLD:      hold_time             <= cfg_data;
        default: ;
      endcase
    end
  end

  // squaring datapath: one axis per cycle
  logic signed [15:0] sq_sel;
  logic [15:0]        sq_abs;
  assign sq_sel = axis[sq_step < 3'd6 ? sq_step : 3'd0];
  assign sq_abs = sq_sel[15] ? 16'(-sq_sel) : sq_sel;

  // averages
  logic [15:0] lin;
  logic [17:0] acc_sum, gyr_sum;
  logic [14:0] roll_abs, pitch_abs;
  logic [15:0] tilt_raw;
  assign lin       = amag >= ONE_G ? amag - ONE_G : ONE_G - amag;
  assign acc_sum   = {2'b0, accel_avg} + {1'b0, accel_avg, 1'b0} + {2'b0, lin} + 18'd2;
  assign gyr_sum   = {2'b0, gyro_avg} + {1'b0, gyro_avg, 1'b0} + {2'b0, gmag} + 18'd2;
  assign roll_abs  = roll[14]  ? 15'(-roll)  : roll;
  assign pitch_abs = pitch[14] ? 15'(-pitch) : pitch;
  assign tilt_raw  = {1'b0, roll_abs} + {1'b0, pitch_abs};

  // ratio operands by divide step
  logic [15:0] rat_v, rat_lvl, rat_r;
  always_comb begin
    unique case (div_idx)
      2'd1:    begin rat_v = accel_avg; rat_lvl = seismic_accel_level; end
      2'd2:    begin rat_v = gyro_avg;  rat_lvl = seismic_gyro_level; end
      default: begin rat_v = {1'b0, tilt_avg}; rat_lvl = {1'b0, landslide_tilt_level}; end
    endcase
  end
  assign rat_r = (rat_lvl == 16'd0 || rat_v >= rat_lvl) ? FULL : quot;

  // confidence dividend: base*FULL + 35*score + 50
  logic [31:0] conf_base;
  always_comb begin
    unique case (rclass)
      CLS_SEISMIC:   conf_base = 32'(65 * 65535);
      CLS_LANDSLIDE: conf_base = 32'(60 * 65535);
      default:       conf_base = 32'(50 * 65535);
    endcase
  end

  // divider operand select
  always_comb begin
    if (state == S_CONF) begin
      div_dividend = conf_base + {11'b0, score, 5'b0} + {15'b0, score, 1'b0}
                     + {16'b0, score} + 32'd50;
      div_divisor  = 16'd100;
    end else if (div_idx == 2'd0) begin
      div_dividend = {15'b0, tilt_avg, 2'b00} + {16'b0, tilt_sat} + 32'd2;
      div_divisor  = 16'd5;
    end else begin
      div_dividend = {rat_v, 16'b0} - {16'b0, rat_v};
      div_divisor  = rat_lvl;
    end
  end

  assign sqrt_start = state == S_ROOT && !launched;
  assign div_start  = (state == S_DIVIDE || state == S_CONF) && !launched;

  mec_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (root_idx ? sum_a : sum_g),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  mec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (quot)
  );

  // rule class from smoothed values
  logic [1:0] rclass_next;
  always_comb begin
    priority if (accel_avg >= seismic_accel_level || gyro_avg >= seismic_gyro_level)
      rclass_next = CLS_SEISMIC;
    else if (tilt_avg >= landslide_tilt_level && accel_avg >= landslide_accel_level)
      rclass_next = CLS_LANDSLIDE;
    else if (accel_avg >= tremor_accel_level || gyro_avg >= tremor_gyro_level)
      rclass_next = CLS_TREMOR;
    else
      rclass_next = CLS_IDLE;
  end

  // merge with model verdict and hold
  logic [SEEN_W-1:0] seen_next;
  logic [1:0]  f_cls, f_src, m_cls, m_src;
  logic [15:0] f_conf, m_conf;
  logic [31:0] left;
  logic        model_ok, rule_ok;
  always_comb begin
    seen_next = samples_seen < SEEN_W'(WINDOW_SAMPLES) ? samples_seen + 1'b1 : samples_seen;
    model_ok  = mvalid && mclass != CLS_IDLE && {mconf, 1'b0} >= {1'b0, FULL};
    rule_ok   = rclass != CLS_IDLE && ({2'b0, score, 2'b0} + {4'b0, score}) >= {4'b0, FULL};
    m_cls  = rclass;
    m_conf = rconf;
    m_src  = seen_next < SEEN_W'(WINDOW_SAMPLES) ? SRC_WARMUP : SRC_RULE;
    if (model_ok) begin
      m_cls = mclass; m_conf = mconf; m_src = SRC_MODEL;
    end
    if (rule_ok && (!mvalid || mclass == CLS_IDLE || mconf < rconf)) begin
      m_cls = rclass; m_conf = rconf; m_src = mvalid ? SRC_RULE_OVER : SRC_RULE;
    end
    left   = hold_deadline - now;
    f_cls  = m_cls;
    f_conf = m_conf;
    f_src  = m_src;
    if (m_cls == CLS_IDLE && held_class != CLS_IDLE && left != 32'd0 && !left[31]) begin
      f_cls = held_class; f_conf = held_conf; f_src = held_source;
    end
  end

  // result valid: set by the merge, cleared when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (merge_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      launched      <= 1'b0;
      accel_avg     <= '0;
      gyro_avg      <= '0;
      tilt_avg      <= '0;
      samples_seen  <= '0;
      held_class    <= CLS_IDLE;
      held_conf     <= '0;
      held_source   <= SRC_WARMUP;
      hold_deadline <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis[0] <= gyro_x;  axis[1] <= gyro_y;  axis[2] <= gyro_z;
            axis[3] <= accel_x; axis[4] <= accel_y; axis[5] <= accel_z;
            roll   <= roll_angle;
            pitch  <= pitch_angle;
            mvalid <= model_valid;
            mclass <= model_class;
            mconf  <= model_confidence;
            now    <= time_ms;
            sum_g  <= '0;
            sum_a  <= '0;
            sq_step <= '0;
            state  <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          prod <= {16'b0, sq_abs} * {16'b0, sq_abs};
          if (sq_step >= 3'd1 && sq_step <= 3'd3) sum_g <= sum_g + prod;
          if (sq_step >= 3'd4) sum_a <= sum_a + prod;
          sq_step <= sq_step + 1'b1;
          if (sq_step == 3'd6) begin
            root_idx <= 1'b0;
            launched <= 1'b0;
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!launched) launched <= 1'b1;
          if (sqrt_done) begin
            launched <= 1'b0;
            if (root_idx) begin
              amag  <= sqrt_root;
              state <= S_AVG;
            end else begin
              gmag     <= sqrt_root;
              root_idx <= 1'b1;
            end
          end
        end
        S_AVG: begin
          accel_avg <= acc_sum[17:2];
          gyro_avg  <= gyr_sum[17:2];
          tilt_sat  <= tilt_raw > TILT_MAX ? TILT_MAX[14:0] : tilt_raw[14:0];
          div_idx   <= 2'd0;
          score     <= '0;
          launched  <= 1'b0;
          state     <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (!launched) launched <= 1'b1;
          if (div_done) begin
            launched <= 1'b0;
            div_idx  <= div_idx + 1'b1;
            if (div_idx == 2'd0) tilt_avg <= quot[14:0];
            else if (rat_r > score) score <= rat_r;
            if (div_idx == 2'd3) state <= S_CLASS;
          end
        end
        S_CLASS: begin
          rclass   <= rclass_next;
          launched <= 1'b0;
          state    <= S_CONF;
        end
        S_CONF: begin
          if (!launched) launched <= 1'b1;
          if (div_done) begin
            launched <= 1'b0;
            rconf    <= rclass == CLS_IDLE ? FULL - score : quot;
            state    <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_fire) begin
            samples_seen <= seen_next;
            if (m_cls != CLS_IDLE) begin
              held_class    <= m_cls;
              held_conf     <= m_conf;
              held_source   <= m_src;
              hold_deadline <= now + {16'b0, hold_time};
            end
            event_class           <= f_cls;
            event_confidence      <= f_conf;
            event_source          <= f_src;
            motion_score          <= score;
            linear_accel_smoothed <= accel_avg;
            gyro_mag_smoothed     <= gyro_avg;
            tilt_smoothed         <= tilt_avg;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a taken sample blocks the input until its result is formed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a sample");

  // a new result appears only out of the merge step
  a_result_from_merge: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(state == S_MERGE))
    else $error("result raised outside merge step");

  // warm-up counter saturates at the window length
  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    samples_seen <= SEEN_W'(WINDOW_SAMPLES))
    else $error("warm-up counter beyond window");

endmodule

// ----- bench/mec_checker.sv -----
// Checker for the motion event classifier: watches the channels, predicts and compares results.
module mec_checker import mec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [14:0] roll_angle,
  input  logic signed [14:0] pitch_angle,
  input  logic               model_valid,
  input  logic [1:0]         model_class,
  input  logic [15:0]        model_confidence,
  input  logic [31:0]        time_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         event_class,
  input  logic [15:0]        event_confidence,
  input  logic [1:0]         event_source,
  input  logic [15:0]        motion_score,
  input  logic [15:0]        linear_accel_smoothed,
  input  logic [15:0]        gyro_mag_smoothed,
  input  logic [14:0]        tilt_smoothed,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fails,
  output int                 pending,
  output int                 results_seen
);

  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] conf;
    logic [1:0]  src;
    logic [15:0] score;
    logic [15:0] accel_avg;
    logic [15:0] gyro_avg;
    logic [14:0] tilt_avg;
  } event_t;

  event_t expected_events[$];
  int     class_hits[4];
  int     source_hits[4];

  // Configured levels and classifier state
  logic [31:0] level_reg[7];
  logic [31:0] accel_avg, gyro_avg, tilt_avg;
  int          warm_count;
  logic [1:0]  held_cls, held_src;
  logic [15:0] held_conf;
  logic [31:0] hold_end;

  function automatic logic [31:0] floor_root(input logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs_val(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] vec_length(input int a, input int b, input int c);
    logic [31:0] sum;
    sum = abs_val(a) * abs_val(a) + abs_val(b) * abs_val(b) + abs_val(c) * abs_val(c);
    return floor_root(sum);
  endfunction

  function automatic logic [31:0] level_ratio(input logic [31:0] v, input logic [31:0] lvl);
    logic [63:0] prod;
    if (lvl == 0 || v >= lvl) return FULL;
    prod = {32'b0, v} * 64'd65535;
    return 32'(prod / lvl);
  endfunction

  function automatic logic [31:0] blend_conf(input logic [31:0] base, input logic [31:0] score);
    logic [31:0] c;
    c = (base * FULL + 35 * score + 50) / 100;
    return (c > FULL) ? FULL : c;
  endfunction

  // Predict the event for one accepted sample; advances the averages and hold
  function automatic event_t classify_sample();
    event_t      e;
    logic [31:0] gmag, amag, lin, tilt, score, r, rconf, fconf, now, left;
    logic [1:0]  rcls, fcls, fsrc;
    gmag = vec_length(gyro_x, gyro_y, gyro_z);
    amag = vec_length(accel_x, accel_y, accel_z);
    lin  = (amag >= ONE_G) ? amag - ONE_G : ONE_G - amag;
    tilt = abs_val(roll_angle) + abs_val(pitch_angle);
    if (tilt > TILT_MAX) tilt = TILT_MAX;
    now = time_ms;

    accel_avg = (3 * accel_avg + lin + 2) >> 2;
    gyro_avg  = (3 * gyro_avg + gmag + 2) >> 2;
    tilt_avg  = (4 * tilt_avg + tilt + 2) / 5;

    score = level_ratio(accel_avg, level_reg[REG_SEISMIC_ACCEL]);
    r = level_ratio(gyro_avg, level_reg[REG_SEISMIC_GYRO]);
    if (r > score) score = r;
    r = level_ratio(tilt_avg, level_reg[REG_LANDSLIDE_TILT]);
    if (r > score) score = r;

    // rule classifier, strongest class first
    if (accel_avg >= level_reg[REG_SEISMIC_ACCEL] || gyro_avg >= level_reg[REG_SEISMIC_GYRO]) begin
      rcls = CLS_SEISMIC;
      rconf = blend_conf(65, score);
    end else if (tilt_avg >= level_reg[REG_LANDSLIDE_TILT] &&
                 accel_avg >= level_reg[REG_LANDSLIDE_ACCEL]) begin
      rcls = CLS_LANDSLIDE;
      rconf = blend_conf(60, score);
    end else if (accel_avg >= level_reg[REG_TREMOR_ACCEL] ||
                 gyro_avg >= level_reg[REG_TREMOR_GYRO]) begin
      rcls = CLS_TREMOR;
      rconf = blend_conf(50, score);
    end else begin
      rcls = CLS_IDLE;
      rconf = FULL - score;
    end

    if (warm_count < WINDOW_SAMPLES) warm_count++;
    fcls = rcls;
    fconf = rconf;
    fsrc = (warm_count < WINDOW_SAMPLES) ? SRC_WARMUP : SRC_RULE;

    // merge with the model verdict
    if (model_valid && model_class != CLS_IDLE && 2 * model_confidence >= FULL) begin
      fcls = model_class;
      fconf = model_confidence;
      fsrc = SRC_MODEL;
    end
    if (rcls != CLS_IDLE && 5 * score >= FULL) begin
      if (!model_valid || model_class == CLS_IDLE || model_confidence < rconf) begin
        fcls = rcls;
        fconf = rconf;
        fsrc = model_valid ? SRC_RULE_OVER : SRC_RULE;
      end
    end

    // hold a non-idle event; wrap-safe deadline compare
    if (fcls != CLS_IDLE) begin
      held_cls = fcls;
      held_conf = fconf[15:0];
      held_src = fsrc;
      hold_end = now + level_reg[REG_EVENT_HOLD];
    end else begin
      left = hold_end - now;
      if (held_cls != CLS_IDLE && left != 0 && left < 32'h8000_0000) begin
        fcls = held_cls;
        fconf = {16'b0, held_conf};
        fsrc = held_src;
      end
    end

    e.cls = fcls;
    e.conf = fconf[15:0];
    e.src = fsrc;
    e.score = score[15:0];
    e.accel_avg = accel_avg[15:0];
    e.gyro_avg = gyro_avg[15:0];
    e.tilt_avg = tilt_avg[14:0];
    return e;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    event_t e;
    if (rst) begin
      expected_events.delete();
      fails = 0;
      results_seen = 0;
      level_reg[REG_TREMOR_ACCEL]    <= 32'd1311;
      level_reg[REG_TREMOR_GYRO]     <= 32'd2304;
      level_reg[REG_SEISMIC_ACCEL]   <= 32'd4588;
      level_reg[REG_SEISMIC_GYRO]    <= 32'd11520;
      level_reg[REG_LANDSLIDE_TILT]  <= 32'd1792;
      level_reg[REG_LANDSLIDE_ACCEL] <= 32'd819;
      level_reg[REG_EVENT_HOLD]      <= 32'd1200;
      accel_avg = 0;
      gyro_avg = 0;
      tilt_avg = 0;
      warm_count = 0;
      held_cls = CLS_IDLE;
      held_conf = 0;
      held_src = SRC_WARMUP;
      hold_end = 0;
    end else begin
      // register write beat
      if (cfg_valid && cfg_ready && cfg_index <= REG_EVENT_HOLD)
        level_reg[cfg_index] <= {16'b0, (cfg_index == REG_LANDSLIDE_TILT) ?
                                         (cfg_data & 16'h7FFF) : cfg_data};
      // sample beat
      if (in_valid && !in_stall)
        expected_events.push_back(classify_sample());
      // result beat
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          fails++;
          $display("%0t: result with no sample waiting, got class %0d", $time, event_class);
        end else begin
          e = expected_events.pop_front();
          class_hits[e.cls]++;
          source_hits[e.src]++;
          check_field("event_class", e.cls, event_class);
          check_field("event_confidence", e.conf, event_confidence);
          check_field("event_source", e.src, event_source);
          check_field("motion_score", e.score, motion_score);
          check_field("linear_accel_smoothed", e.accel_avg, linear_accel_smoothed);
          check_field("gyro_mag_smoothed", e.gyro_avg, gyro_mag_smoothed);
          check_field("tilt_smoothed", e.tilt_avg, tilt_smoothed);
        end
      end
    end
    pending <= expected_events.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the motion event classifier bench: clock, reset, stimulus and verdict.
module testbench;
  import mec_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [14:0] roll_angle = '0, pitch_angle = '0;
  logic               model_valid = 1'b0;
  logic [1:0]         model_class = CLS_IDLE;
  logic [15:0]        model_confidence = '0;
  logic [31:0]        time_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         event_class;
  logic [15:0]        event_confidence;
  logic [1:0]         event_source;
  logic [15:0]        motion_score;
  logic [15:0]        linear_accel_smoothed;
  logic [15:0]        gyro_mag_smoothed;
  logic [14:0]        tilt_smoothed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_TREMOR_ACCEL;
  logic [15:0]        cfg_data = '0;

  int fails, pending, results_seen;
  int samples_sent = 0;
  int writes_done = 0;
  int cycles = 0;
  logic [31:0] clock_ms = 32'd0;

  motion_event_classifier u_dut (.*);

  mec_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending);
      $display("[motion_event_classifier] ERROR");
      $finish;
    end
  end

  // result-side back-pressure: quiet stretches, short blips and long holds
  int stall_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    end
  end

  task automatic idle_gap();
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: gap = 0;
      6, 7, 8:          gap = $urandom_range(1, 4);
      default:          gap = $urandom_range(10, 60);
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one sample beat; holds until accepted
  task automatic send_sample(input logic [15:0] gx, gy, gz, ax, ay, az,
                             input logic [14:0] rl, pt,
                             input logic mv, input logic [1:0] mc,
                             input logic [15:0] mconf, input logic [31:0] ts);
    idle_gap();
    gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    roll_angle <= rl; pitch_angle <= pt;
    model_valid <= mv; model_class <= mc; model_confidence <= mconf;
    time_ms <= ts;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  // one write beat; the caller drops valid after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    writes_done++;
  endtask

  task automatic load_levels(input logic [15:0] ta, tg, sa, sg, lt, la, hold);
    write_reg(REG_TREMOR_ACCEL, ta);
    write_reg(REG_TREMOR_GYRO, tg);
    write_reg(REG_SEISMIC_ACCEL, sa);
    write_reg(REG_SEISMIC_GYRO, sg);
    write_reg(REG_LANDSLIDE_TILT, lt);
    write_reg(REG_LANDSLIDE_ACCEL, la);
    write_reg(REG_EVENT_HOLD, hold);
    cfg_valid <= 1'b0;
  endtask

  // let every result drain, then idle a while
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] around(input int center, input int spread);
    return 16'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // random sample; mostly plausible motion, some full-range noise
  task automatic random_sample();
    logic [15:0] gx, gy, gz, ax, ay, az, mconf;
    logic [14:0] rl, pt;
    int          gs, as, ts;
    gs = ($urandom_range(0, 3) == 0) ? 32767 : (1 << $urandom_range(2, 13));
    as = ($urandom_range(0, 3) == 0) ? 32767 : (1 << $urandom_range(2, 12));
    ts = ($urandom_range(0, 4) == 0) ? 16383 : (1 << $urandom_range(3, 12));
    gx = around(0, gs); gy = around(0, gs); gz = around(0, gs);
    ax = around(0, as); ay = around(0, as); az = around(16384, as);
    rl = 15'(around(0, ts)); pt = 15'(around(0, ts));
    if ($urandom_range(0, 9) == 0) begin
      gx = 16'($urandom); ax = 16'($urandom); az = 16'($urandom);
      rl = 15'($urandom); pt = 15'($urandom);
    end
    mconf = ($urandom_range(0, 2) == 0) ? around(32767, 2) : 16'($urandom);
    // time mostly steps 10 ms; sometimes jumps, near-wrap or backwards
    case ($urandom_range(0, 19))
      0:       clock_ms = $urandom;
      1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      2:       clock_ms = clock_ms + $urandom_range(0, 70000);
      3:       clock_ms = clock_ms - $urandom_range(0, 500);
      default: clock_ms = clock_ms + 10;
    endcase
    send_sample(gx, gy, gz, ax, ay, az, rl, pt, 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)), mconf, clock_ms);
  endtask

  task automatic random_run(input int count);
    repeat (count) random_sample();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, model merge corners, tilt saturation, time wrap
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 0, CLS_IDLE, 0, 0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                15'h4000, 15'h4000, 1, CLS_SEISMIC, 16'hFFFF, 10);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                15'h3FFF, 15'h3FFF, 1, CLS_TREMOR, 16'd32767, 20);
    send_sample(0, 0, 0, 0, 0, 0, 11520, -11520, 1, CLS_LANDSLIDE, 16'd32768, 30);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 1, CLS_IDLE, 16'hFFFF, 40);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 0, CLS_SEISMIC, 16'hFFFF, 50);
    send_sample(100, -100, 50, 0, 0, 16384, 0, 0, 1, CLS_TREMOR, 16'd32768, 1240);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 0, CLS_IDLE, 0, 1250);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 0, CLS_IDLE, 0, 2440);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 0, CLS_IDLE, 0, 2450);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 1, CLS_SEISMIC, 16'd40000, 32'hFFFF_FF00);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 0, CLS_IDLE, 0, 32'h0000_0010);
    send_sample(0, 0, 0, 0, 0, 16384, 0, 0, 0, CLS_IDLE, 0, 32'h8000_0000);
    send_sample(20000, 20000, 0, 30000, 0, 0, -16384, -16384, 1, CLS_TREMOR, 16'd65000, 5000);
    send_sample(20000, 20000, 0, 30000, 0, 0, -16384, -16384, 1, CLS_LANDSLIDE, 16'd100, 5010);
    send_sample(0, 0, 0, 0, 0, 16384, 16383, 16383, 0, CLS_IDLE, 0, 5020);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                15'h2AAA, 15'h5555, 1, CLS_SEISMIC, 16'hAAAA, 32'hAAAA_AAAA);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                15'h5555, 15'h2AAA, 1, CLS_SEISMIC, 16'h5555, 32'h5555_5555);
    clock_ms = 32'h5555_5555;
    random_run(500);

    // zero levels and zero hold
    drain();
    load_levels(0, 0, 0, 0, 0, 0, 0);
    random_run(150);

    // top levels and longest hold
    drain();
    load_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    random_run(150);

    // random but sensible levels
    repeat (4) begin
      drain();
      load_levels(16'($urandom_range(100, 4000)), 16'($urandom_range(100, 8000)),
                  16'($urandom_range(2000, 12000)), 16'($urandom_range(4000, 30000)),
                  16'($urandom_range(200, 6000)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 3000)));
      random_run(250);
    end

    drain();
    $display("%0d samples, %0d results, %0d register writes over seven level settings",
             samples_sent, results_seen, writes_done);
    $display("classes idle/tremor/landslide/seismic: %0d/%0d/%0d/%0d",
             u_check.class_hits[0], u_check.class_hits[1],
             u_check.class_hits[2], u_check.class_hits[3]);
    if (fails == 0 && pending == 0) begin
      $display("[motion_event_classifier] OK");
    end else begin
      $display("[motion_event_classifier] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mec_pkg.sv
hw/rtl/mec_sqrt.sv
hw/rtl/mec_div.sv
hw/rtl/motion_event_classifier.sv
bench/mec_checker.sv
bench/testbench.sv
